// ===== design/lrukv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared types and constants of the lru key-value cache.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  // default geometry
  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  // capacity register
  localparam int         CAP_W     = 5;
  localparam logic [4:0] CAP_RESET = 5'd16;

  // action codes carried in s_tuser
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOOK,
    B_APPLY
  } back_state_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    logic put;
  } cmd_ctl_t;

endpackage

// ===== design/lrukv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_front
// Accepts input words, classifies them as get or put and holds them in a
// two-word command queue until the back end takes them.
// ----------------------------------------------------------------------------
module lrukv_front import lrukv_pkg::*; #(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  output cmd_ctl_t              cmd_ctl,
  output logic [KEY_BITS-1:0]   cmd_key,
  output logic [VALUE_BITS-1:0] cmd_value,
  input  logic                  cmd_ready
);

  logic                  q_put   [QUEUE_DEPTH];
  logic [KEY_BITS-1:0]   q_key   [QUEUE_DEPTH];
  logic [VALUE_BITS-1:0] q_value [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QCNT_W-1:0]     count;
  logic                  push;
  logic                  pop;

  assign in_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = cmd_ctl.valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_put[wr_ptr]   <= (in_action == ACT_PUT);
      q_key[wr_ptr]   <= in_key;
      q_value[wr_ptr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign cmd_ctl.valid = (count != '0);
  assign cmd_ctl.put   = q_put[rd_ptr];
  assign cmd_key       = q_key[rd_ptr];
  assign cmd_value     = q_value[rd_ptr];

endmodule

// ===== design/lrukv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_back
// Entry store with recency ranks: searches all entries for a command, then
// applies the hit, update or insert and loads the result register.
// ----------------------------------------------------------------------------
module lrukv_back import lrukv_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CNT_W-1:0]      eff_cap,
  input  cmd_ctl_t              cmd_ctl,
  input  logic [KEY_BITS-1:0]   cmd_key,
  input  logic [VALUE_BITS-1:0] cmd_value,
  output logic                  cmd_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [VALUE_BITS-1:0] out_value
);

  back_state_t state;
  back_state_t state_next;

  logic                  valid [ENTRIES];
  logic [KEY_BITS-1:0]   keys  [ENTRIES];
  logic [VALUE_BITS-1:0] data  [ENTRIES];
  logic [IDX_W-1:0]      rank  [ENTRIES];
  logic [CNT_W-1:0]      occ;

  // command being worked on
  logic                  c_put;
  logic [KEY_BITS-1:0]   c_key;
  logic [VALUE_BITS-1:0] c_value;

  // registered search results
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      hit_rank;
  logic [VALUE_BITS-1:0] hit_data;
  logic                  evict;
  logic [IDX_W-1:0]      slot;

  // search logic
  logic                  s_hit;
  logic [IDX_W-1:0]      s_hit_idx;
  logic [IDX_W-1:0]      s_victim;
  logic [IDX_W-1:0]      s_free;
  logic [IDX_W-1:0]      lru_rank;
  logic                  s_evict;

  logic take;
  logic look;
  logic apply_en;

  // ---------------- control ----------------
  always_comb begin
    take     = 1'b0;
    look     = 1'b0;
    apply_en = 1'b0;
    unique case (state)
      B_IDLE:  take = 1'b1;
      B_LOOK:  look = 1'b1;
      B_APPLY: apply_en = c_put || !out_valid || out_ready;
      default: ;
    endcase
  end

  assign cmd_ready = take;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (cmd_ctl.valid) state_next = B_LOOK;
      B_LOOK:  state_next = B_APPLY;
      B_APPLY: if (apply_en) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // ---------------- search ----------------
  // ranks of valid entries are 0..occ-1, so the least recent is rank occ-1
  assign lru_rank = IDX_W'(occ - 1'b1);
  assign s_evict  = (occ >= eff_cap) || (occ >= CNT_W'(ENTRIES));

  always_comb begin
    s_hit     = 1'b0;
    s_hit_idx = '0;
    s_victim  = '0;
    s_free    = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == c_key) begin
        s_hit     = 1'b1;
        s_hit_idx = IDX_W'(i);
      end
      if (valid[i] && rank[i] == lru_rank) s_victim = IDX_W'(i);
      if (!valid[i]) s_free = IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      c_put   <= cmd_ctl.put;
      c_key   <= cmd_key;
      c_value <= cmd_value;
    end
    if (look) begin
      hit      <= s_hit;
      hit_idx  <= s_hit_idx;
      hit_rank <= rank[s_hit_idx];
      hit_data <= data[s_hit_idx];
      evict    <= s_evict;
      slot     <= s_evict ? s_victim : s_free;
    end
  end

  // ---------------- store update ----------------
  always_ff @(posedge clk) begin
    if (apply_en && c_put) begin
      if (hit) begin
        data[hit_idx] <= c_value;
      end else begin
        keys[slot] <= c_key;
        data[slot] <= c_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] <= 1'b0;
        rank[i]  <= '0;
      end
      occ <= '0;
    end else if (apply_en) begin
      if (hit) begin
        // touch: younger entries age by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == hit_idx) begin
            rank[i] <= '0;
          end else if (valid[i] && rank[i] < hit_rank) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
      end else if (c_put) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == slot) begin
            rank[i] <= '0;
          end else if (valid[i]) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
        valid[slot] <= 1'b1;
        if (!evict) occ <= occ + 1'b1;
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_en && !c_put) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_en && !c_put) begin
      out_found <= hit;
      out_value <= hit ? hit_data : '0;
    end
  end

endmodule

// ===== design/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A get or put word is taken into a two-word command queue whenever the
// queue has room. The back end works one command at a time in steps
// (take from queue, parallel key and rank search over all entries, apply)
// and takes no new command until the last is applied; a get's result waits
// in an output register and the apply step of the next get holds until that
// register is free. Puts give no result word. The store is empty right after
// reset with no clearing pass. Write capacity only while the block is idle;
// zero acts as one and values above ENTRIES act as ENTRIES.
module lru_key_value_cache import lrukv_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IN_DATA_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // key, value
  input  logic [0:0]            s_tuser,   // action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // read_value
  output logic [0:0]            m_tuser,   // found
  input  logic                  cfg_we,
  input  logic [CAP_W-1:0]      cfg_wdata
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [CAP_W-1:0]      capacity;
  logic [CNT_W-1:0]      eff_cap;
  cmd_ctl_t              cmd_ctl;
  logic [KEY_BITS-1:0]   cmd_key;
  logic [VALUE_BITS-1:0] cmd_value;
  logic                  cmd_ready;
  logic                  out_found;
  logic [VALUE_BITS-1:0] out_value;

  always_ff @(posedge clk) begin
    if (rst)         capacity <= CAP_RESET;
    else if (cfg_we) capacity <= cfg_wdata;
  end

  always_comb begin
    if (capacity == '0)              eff_cap = CNT_W'(1);
    else if (32'(capacity) > ENTRIES) eff_cap = CNT_W'(ENTRIES);
    else                             eff_cap = CNT_W'(capacity);
  end

  lrukv_front #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser[0]),
    .in_key    (s_tdata[KEY_BITS-1:0]),
    .in_value  (s_tdata[KEY_BITS +: VALUE_BITS]),
    .cmd_ctl   (cmd_ctl),
    .cmd_key   (cmd_key),
    .cmd_value (cmd_value),
    .cmd_ready (cmd_ready)
  );

  lrukv_back #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .eff_cap   (eff_cap),
    .cmd_ctl   (cmd_ctl),
    .cmd_key   (cmd_key),
    .cmd_value (cmd_value),
    .cmd_ready (cmd_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_found (out_found),
    .out_value (out_value)
  );

  assign m_tdata    = OUT_DATA_W'(out_value);
  assign m_tuser[0] = out_found;

endmodule

// ===== design/lrukv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_checker
// Port-level checks of the lru key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lrukv_checker #(
  parameter int IN_W  = 48,
  parameter int OUT_W = 32
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic [0:0]       s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic [0:0]       m_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // a miss carries zero data
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("miss word with nonzero data");

  // leaving reset: no result pending, queue ready
  a_reset_state: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid && s_tready)
    else $error("bad state after reset");

  // an offered result word is fully known
  a_out_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !$isunknown({m_tuser, m_tdata}))
    else $error("unknown result word");

  // a word can only be taken when the data on the input is meaningful
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !$isunknown({s_tuser, s_tdata}))
    else $error("unknown input word accepted");

endmodule

bind lru_key_value_cache lrukv_checker #(
  .IN_W  (IN_DATA_W),
  .OUT_W (OUT_DATA_W)
) u_lrukv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
